FILE: rtl/work_countdown_timer_control_defines.svh
`ifndef WORK_COUNTDOWN_TIMER_CONTROL_DEFINES_SVH
`define WORK_COUNTDOWN_TIMER_CONTROL_DEFINES_SVH

// same-cycle implication, held off during reset
`define WCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define WCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wct_pkg.sv
`timescale 1ns / 1ps
package wct_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_SET    = 3'd1,
		MODE_PAUSED = 3'd2,
		MODE_COUNT  = 3'd3,
		MODE_STATS  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		EV_INC   = 3'd0,
		EV_DEC   = 3'd1,
		EV_START = 3'd2,
		EV_ABORT = 3'd3,
		EV_TICK  = 3'd4
	} cmd_t;

	localparam logic [2:0] REG_STEP_SECONDS     = 3'd0;
	localparam logic [2:0] REG_MAX_SECONDS      = 3'd1;
	localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd2;
	localparam logic [2:0] REG_BUZZ_EVERY       = 3'd3;
	localparam logic [2:0] REG_BUZZ_LIMIT       = 3'd4;

	localparam logic [11:0] RST_STEP_SECONDS     = 12'd60;
	localparam logic [15:0] RST_MAX_SECONDS      = 16'd59940;
	localparam logic [3:0]  RST_TICKS_PER_SECOND = 4'd10;
	localparam logic [3:0]  RST_BUZZ_EVERY       = 4'd5;
	localparam logic [4:0]  RST_BUZZ_LIMIT       = 5'd20;

	// bit s set when s is a multiple of the divisor; zero divisor never hits
	function automatic logic [15:0] buzz_mask(input logic [3:0] div);
		logic [15:0] m;
		case (div)
			4'd1:    m = 16'hFFFF;
			4'd2:    m = 16'h5555;
			4'd3:    m = 16'h9249;
			4'd4:    m = 16'h1111;
			4'd5:    m = 16'h8421;
			4'd6:    m = 16'h1041;
			4'd7:    m = 16'h4081;
			4'd8:    m = 16'h0101;
			4'd9:    m = 16'h0201;
			4'd10:   m = 16'h0401;
			4'd11:   m = 16'h0801;
			4'd12:   m = 16'h1001;
			4'd13:   m = 16'h2001;
			4'd14:   m = 16'h4001;
			4'd15:   m = 16'h8001;
			default: m = 16'h0000;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/work_countdown_timer_control.sv
// Countdown timer controller. One event beat (cmd in tuser, sub_tick in tdata) can be
// taken every clock while results drain. An accepted event is held in the event register
// until the result register can take it. The whole mode update is done combinationally,
// between the event register and the result register, and the result beat is presented
// from the result register until it is taken.
// s_axis_tready follows m_axis_tready combinationally. While a result waits, the event
// register holds one more beat, and input then stalls until the result is taken.
// Configuration writes are accepted every cycle and must be issued only while
// no event is in flight.
`timescale 1ns / 1ps
`include "work_countdown_timer_control_defines.svh"
module work_countdown_timer_control
	import wct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [3:0] sub_tick, [7:4] zero
	input  logic [2:0]  s_axis_tuser,  // [2:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [2:0] mode, [18:3] remaining_seconds,
	                                   // [50:19] productive_seconds, [51] buzz, [55:52] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [11:0] step_q;
	logic [15:0] max_q;
	logic [3:0]  tps_q;
	logic [3:0]  buzz_every_q;
	logic [4:0]  buzz_limit_q;

	mode_t       mode_q;
	logic [15:0] remaining_q;
	logic [15:0] elapsed_q;
	logic [31:0] prod_q;
	logic [4:0]  buzz_count_q;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [3:0]  sub_s1;

	logic        valid_s2;
	mode_t       mode_s2;
	logic [15:0] remaining_s2;
	logic [31:0] prod_s2;
	logic        buzz_s2;

	logic        advance;

	mode_t       mode_d;
	logic [15:0] remaining_d;
	logic [15:0] elapsed_d;
	logic [31:0] prod_d;
	logic [4:0]  buzz_count_d;
	logic        buzz_d;

	logic [16:0] add_sum;
	logic        can_add;
	logic        second_hit;
	logic [15:0] rem_dec;
	logic [15:0] el_inc;
	logic [32:0] flush_sum;
	logic [31:0] flush_sat;
	logic [15:0] buzz_hits;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, buzz_s2, prod_s2, remaining_s2, mode_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= RST_STEP_SECONDS;
			max_q        <= RST_MAX_SECONDS;
			tps_q        <= RST_TICKS_PER_SECOND;
			buzz_every_q <= RST_BUZZ_EVERY;
			buzz_limit_q <= RST_BUZZ_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STEP_SECONDS:     step_q       <= cfg_data[11:0];
				REG_MAX_SECONDS:      max_q        <= cfg_data;
				REG_TICKS_PER_SECOND: tps_q        <= cfg_data[3:0];
				REG_BUZZ_EVERY:       buzz_every_q <= cfg_data[3:0];
				REG_BUZZ_LIMIT:       buzz_limit_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
			sub_s1 <= s_axis_tdata[3:0];
		end
	end

	assign add_sum    = {1'b0, remaining_q} + {5'd0, step_q};
	assign can_add    = add_sum <= {1'b0, max_q};
	assign second_hit = (cmd_s1 == EV_TICK) && (sub_s1 == tps_q);
	assign rem_dec    = (remaining_q != 16'd0) ? remaining_q - 16'd1 : remaining_q;
	assign el_inc     = (remaining_q != 16'd0 && elapsed_q != 16'hFFFF) ?
	                    elapsed_q + 16'd1 : elapsed_q;
	assign buzz_hits  = buzz_mask(buzz_every_q);

	always_comb begin
		mode_d       = mode_q;
		remaining_d  = remaining_q;
		elapsed_d    = elapsed_q;
		buzz_count_d = buzz_count_q;
		buzz_d       = 1'b0;
		flush_sum    = {1'b0, prod_q} + {17'd0, elapsed_q};
		flush_sat    = flush_sum[32] ? 32'hFFFF_FFFF : flush_sum[31:0];
		prod_d       = prod_q;
		case (mode_q)
			MODE_IDLE: begin
				remaining_d = 16'd0;
				elapsed_d   = 16'd0;
				case (cmd_s1)
					EV_INC: begin
						if ({4'd0, step_q} <= max_q) begin
							mode_d       = MODE_SET;
							remaining_d  = {4'd0, step_q};
							buzz_count_d = 5'd0;
						end
					end
					EV_START: mode_d = MODE_STATS;
					EV_TICK: begin
						if (buzz_count_q < buzz_limit_q && buzz_hits[sub_s1]) begin
							buzz_d       = 1'b1;
							buzz_count_d = buzz_count_q + 5'd1;
						end
					end
					default: ;
				endcase
			end
			MODE_SET, MODE_PAUSED: begin
				case (cmd_s1)
					EV_INC: begin
						if (can_add) begin
							remaining_d = add_sum[15:0];
							mode_d      = MODE_SET;
						end
					end
					EV_DEC: begin
						if (remaining_q > {4'd0, step_q}) begin
							remaining_d = remaining_q - {4'd0, step_q};
							mode_d      = MODE_SET;
						end else begin
							remaining_d = 16'd0;
							mode_d      = MODE_IDLE;
						end
					end
					EV_START: mode_d = MODE_COUNT;
					EV_ABORT: begin
						remaining_d = 16'd0;
						mode_d      = MODE_IDLE;
					end
					default: ;
				endcase
			end
			MODE_COUNT: begin
				if (cmd_s1 == EV_START || cmd_s1 == EV_ABORT) begin
					prod_d    = flush_sat;
					elapsed_d = 16'd0;
					mode_d    = (cmd_s1 == EV_START) ? MODE_PAUSED : MODE_IDLE;
				end else if (second_hit) begin
					remaining_d = rem_dec;
					elapsed_d   = el_inc;
					if (rem_dec == 16'd0) begin
						flush_sum = {1'b0, prod_q} + {17'd0, el_inc};
						flush_sat = flush_sum[32] ? 32'hFFFF_FFFF : flush_sum[31:0];
						prod_d    = flush_sat;
						elapsed_d = 16'd0;
						mode_d    = MODE_IDLE;
					end
				end
			end
			default: begin
				if (second_hit) begin
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			remaining_q  <= 16'd0;
			elapsed_q    <= 16'd0;
			prod_q       <= 32'd0;
			buzz_count_q <= 5'd0;
		end else if (advance) begin
			mode_q       <= mode_d;
			remaining_q  <= remaining_d;
			elapsed_q    <= elapsed_d;
			prod_q       <= prod_d;
			buzz_count_q <= buzz_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2      <= mode_d;
			remaining_s2 <= remaining_d;
			prod_s2      <= prod_d;
			buzz_s2      <= buzz_d;
		end
	end

	`WCT_ASSERT_NOW(a_elapsed_only_counting, mode_q != MODE_COUNT, elapsed_q == 16'd0,
		"elapsed time held outside counting mode")
	`WCT_ASSERT_NEXT(a_total_monotonic, advance, prod_q >= $past(prod_q),
		"productive total decreased")
	`WCT_ASSERT_NEXT(a_advance_loads_result, advance, valid_s2,
		"processed event produced no result")
	`WCT_ASSERT_NOW(a_buzz_in_idle, valid_s2 && buzz_s2, mode_s2 == MODE_IDLE,
		"buzz outside idle mode")

endmodule

FILE: tb/sv/work_countdown_timer_control_test.sv
`timescale 1ns / 1ps
module work_countdown_timer_control_test;
	import wct_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int LONG_HOLD = 60;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [2:0] REG_UNUSED = 3'd7;

	class countdown_scoreboard;
		typedef struct packed {
			mode_t       mode;
			logic [15:0] remaining;
			logic [31:0] productive;
			logic        buzz;
		} outcome_t;

		logic [11:0] step_s;
		logic [15:0] max_s;
		logic [3:0]  tick_match;
		logic [3:0]  buzz_div;
		logic [4:0]  buzz_cap;
		mode_t       mode;
		logic [15:0] remain;
		logic [15:0] worked;
		logic [31:0] total;
		logic [4:0]  buzz_cnt;
		outcome_t    pending[$];
		int          errors;

		function new();
			step_s = RST_STEP_SECONDS;
			max_s = RST_MAX_SECONDS;
			tick_match = RST_TICKS_PER_SECOND;
			buzz_div = RST_BUZZ_EVERY;
			buzz_cap = RST_BUZZ_LIMIT;
			mode = MODE_IDLE;
			remain = '0;
			worked = '0;
			total = '0;
			buzz_cnt = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_STEP_SECONDS: step_s = val[11:0];
				REG_MAX_SECONDS: max_s = val;
				REG_TICKS_PER_SECOND: tick_match = val[3:0];
				REG_BUZZ_EVERY: buzz_div = val[3:0];
				REG_BUZZ_LIMIT: buzz_cap = val[4:0];
				default: ;
			endcase
		endfunction

		function void bank_worked();
			logic [32:0] sum;
			sum = {1'b0, total} + {17'd0, worked};
			total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			worked = '0;
		endfunction

		function bit room_for_step();
			return ({16'd0, remain} + {20'd0, step_s}) <= {16'd0, max_s};
		endfunction

		function void note_event(logic [2:0] c, logic [3:0] s);
			outcome_t o;
			logic     bz;
			bz = 1'b0;
			case (mode)
				MODE_IDLE: begin
					remain = '0;
					worked = '0;
					if (c == EV_INC) begin
						if (room_for_step()) begin
							mode = MODE_SET;
							remain = {4'd0, step_s};
							buzz_cnt = '0;
						end
					end else if (c == EV_START) begin
						mode = MODE_STATS;
					end else if (c == EV_TICK) begin
						if (buzz_div != 0 && buzz_cnt < buzz_cap && s % buzz_div == 0) begin
							bz = 1'b1;
							buzz_cnt = buzz_cnt + 5'd1;
						end
					end
				end
				MODE_SET, MODE_PAUSED: begin
					if (c == EV_INC) begin
						if (room_for_step()) begin
							remain = remain + {4'd0, step_s};
							mode = MODE_SET;
						end
					end else if (c == EV_DEC) begin
						if (remain > {4'd0, step_s}) begin
							remain = remain - {4'd0, step_s};
							mode = MODE_SET;
						end else begin
							remain = '0;
							mode = MODE_IDLE;
						end
					end else if (c == EV_START) begin
						mode = MODE_COUNT;
					end else if (c == EV_ABORT) begin
						remain = '0;
						mode = MODE_IDLE;
					end
				end
				MODE_COUNT: begin
					if (c == EV_START) begin
						bank_worked();
						mode = MODE_PAUSED;
					end else if (c == EV_ABORT) begin
						bank_worked();
						mode = MODE_IDLE;
					end else if (c == EV_TICK && s == tick_match) begin
						if (remain != 0) begin
							remain = remain - 16'd1;
							if (worked != 16'hFFFF)
								worked = worked + 16'd1;
						end
						if (remain == 0) begin
							bank_worked();
							mode = MODE_IDLE;
						end
					end
				end
				default: begin
					if (c == EV_TICK && s == tick_match)
						mode = MODE_IDLE;
				end
			endcase
			o.mode = mode;
			o.remaining = remain;
			o.productive = total;
			o.buzz = bz;
			pending.push_back(o);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(logic [55:0] d);
			outcome_t o;
			if (pending.size() == 0) begin
				report("unexpected beat, mode", {29'd0, d[2:0]}, 0);
			end else begin
				o = pending.pop_front();
				if (d[2:0] !== o.mode)
					report("mode", {29'd0, d[2:0]}, {29'd0, o.mode});
				if (d[18:3] !== o.remaining)
					report("remaining_seconds", {16'd0, d[18:3]}, {16'd0, o.remaining});
				if (d[50:19] !== o.productive)
					report("productive_seconds", d[50:19], o.productive);
				if (d[51] !== o.buzz)
					report("buzz", {31'd0, d[51]}, {31'd0, o.buzz});
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	countdown_scoreboard sb;
	bit send_gaps;
	bit take_gaps;
	bit hold_req;
	int cycles;

	work_countdown_timer_control DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready = 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (take_gaps && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				n = $urandom_range(1, 9);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	task send_event(input logic [2:0] c, input logic [3:0] s);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {4'd0, s};
		s_axis_tuser = c;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_event(c, s);
		@(negedge clk);
	endtask

	task wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_cfg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task load_settings(input logic [15:0] step, input logic [15:0] top, input logic [15:0] tps,
			input logic [15:0] every, input logic [15:0] cap);
		wait_drained();
		write_cfg(REG_STEP_SECONDS, step);
		write_cfg(REG_MAX_SECONDS, top);
		write_cfg(REG_TICKS_PER_SECOND, tps);
		write_cfg(REG_BUZZ_EVERY, every);
		write_cfg(REG_BUZZ_LIMIT, cap);
	endtask

	// bias the next event toward what moves the current mode forward
	task send_shaped();
		logic [2:0] c;
		logic [3:0] s;
		int r;
		r = $urandom_range(0, 99);
		c = 3'($urandom_range(0, 7));
		s = 4'($urandom_range(0, 15));
		case (sb.mode)
			MODE_IDLE: begin
				if (r < 55)
					c = EV_INC;
				else if (r < 75)
					c = EV_TICK;
				else if (r < 83)
					c = EV_START;
			end
			MODE_SET, MODE_PAUSED: begin
				if (r < 35)
					c = EV_INC;
				else if (r < 50)
					c = EV_DEC;
				else if (r < 85)
					c = EV_START;
				else if (r < 90)
					c = EV_ABORT;
			end
			MODE_COUNT: begin
				if (r < 75) begin
					c = EV_TICK;
					if ($urandom_range(0, 4) != 0)
						s = sb.tick_match;
				end else if (r < 83) begin
					c = EV_START;
				end else if (r < 87) begin
					c = EV_ABORT;
				end
			end
			default: begin
				if (r < 60) begin
					c = EV_TICK;
					if ($urandom_range(0, 1) != 0)
						s = sb.tick_match;
				end
			end
		endcase
		send_event(c, s);
	endtask

	task run_random(input int count);
		repeat (count) send_shaped();
		s_axis_tvalid = 1'b0;
	endtask

	task random_settings();
		logic [15:0] top;
		top = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(1, 40));
		load_settings(16'($urandom_range(1, 6)) | (16'($urandom) << 12), top,
			16'($urandom_range(0, 15)) | (16'($urandom) << 4),
			16'($urandom_range(0, 15)) | (16'($urandom) << 4),
			16'($urandom_range(0, 31)) | (16'($urandom) << 5));
	endtask

	initial begin
		sb = new();
		cycles = 0;
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle buzz, unknown and ignored events, then set, count, pause, abort, stats
		send_event(EV_TICK, 4'd0);
		send_event(EV_TICK, 4'd15);
		send_event(EV_TICK, 4'd7);
		send_event(3'd5, 4'd0);
		send_event(3'd6, 4'd15);
		send_event(3'd7, 4'd3);
		send_event(EV_DEC, 4'd0);
		send_event(EV_ABORT, 4'd0);
		send_event(EV_INC, 4'd0);
		send_event(EV_INC, 4'd0);
		send_event(EV_DEC, 4'd0);
		send_event(3'd7, 4'd0);
		send_event(EV_START, 4'd0);
		send_event(EV_TICK, 4'd10);
		send_event(EV_TICK, 4'd3);
		send_event(EV_INC, 4'd0);
		send_event(EV_START, 4'd0);
		send_event(EV_DEC, 4'd0);
		send_event(EV_INC, 4'd0);
		send_event(EV_START, 4'd0);
		send_event(EV_TICK, 4'd10);
		send_event(EV_ABORT, 4'd0);
		send_event(EV_TICK, 4'd10);
		send_event(EV_START, 4'd0);
		send_event(EV_TICK, 4'd9);
		send_event(EV_TICK, 4'd10);
		s_axis_tvalid = 1'b0;

		// hold the result side long while events keep coming
		load_settings(16'd1, 16'd5, 16'd15, 16'd1, 16'd31);
		send_gaps = 1'b0;
		take_gaps = 1'b1;
		hold_req = 1'b1;
		run_random(60);

		load_settings(16'd4095, 16'd65535, 16'd1, 16'd15, 16'd0);
		send_gaps = 1'b1;
		run_random(50);

		load_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd3);
		write_cfg(REG_UNUSED, 16'($urandom));
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		run_random(50);

		repeat (3) begin
			random_settings();
			send_gaps = $urandom_range(0, 3) != 0;
			take_gaps = $urandom_range(0, 3) != 0;
			run_random(60);
		end

		random_settings();
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		run_random(60);

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report("beats still owed", sb.pending.size(), 0);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
